// ===== rtl/free_list_pool_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// free_list_pool_allocator_defines
// assertion macros shared by the pool allocator rtl
// ----------------------------------------------------------------------------
`ifndef FREE_LIST_POOL_ALLOCATOR_DEFINES_SVH
`define FREE_LIST_POOL_ALLOCATOR_DEFINES_SVH

`ifndef SYNTHESIS

// immediate implication, checked on every clock edge outside reset
`define FLPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the following cycle
`define FLPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FLPA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define FLPA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/flpa_pkg.sv =====
// ----------------------------------------------------------------------------
// flpa_pkg
// types and constants for the free list pool allocator
// ----------------------------------------------------------------------------
`default_nettype none

package flpa_pkg;

    localparam int BLOCK_ENTRIES = 256;
    localparam int MAX_BLOCKS    = 16;

    localparam int INDEX_W     = 12;
    localparam int INDEX_SPACE = 1 << INDEX_W;
    localparam int LINK_W      = INDEX_W + 1;
    localparam int COUNT_W     = INDEX_W + 1;
    localparam int POS_W       = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
    localparam int FIT_BLOCKS  = INDEX_SPACE / BLOCK_ENTRIES;
    localparam int BLOCK_LIMIT = (MAX_BLOCKS < FIT_BLOCKS) ? MAX_BLOCKS : FIT_BLOCKS;

    localparam int              CFG_W     = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_REUSED    = 3'd0,
        ST_FRESH     = 3'd1,
        ST_EXHAUSTED = 3'd2,
        ST_FREED     = 3'd3,
        ST_REJECTED  = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_POP
    } t_state;

    typedef struct packed {
        logic [INDEX_W-1:0] granted_index;
        t_status            status;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/free_list_pool_allocator.sv =====
// ----------------------------------------------------------------------------
// free_list_pool_allocator
// fixed entry pool allocator with a lifo reuse list held in a link ram
// ----------------------------------------------------------------------------
// An allocate request pops the head of the reuse list, or when the list is
// empty issues a fresh entry (top index of each block downward, block after
// block, up to the configured block count); with neither it reports the pool
// exhausted. A free request pushes the entry onto the list, or is rejected
// when the index lies outside the pool. Each request beat yields exactly one
// result beat. Frees, fresh issues, exhaustion and rejections are resolved in
// the cycle of acceptance; a pop passes through S_IDLE and then S_POP, since
// the link of the head comes from the link ram in the cycle after the read is
// issued. Requests are handled one at a time and results wait in a two entry
// queue, so up to two results may sit untaken before the request side stalls.
// The link ram has no reset: no entry is read before a free has written it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "free_list_pool_allocator_defines.svh"

module free_list_pool_allocator
    import flpa_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_W-1:0]   i_cfg_data,
    input  wire logic               i_req_valid,
    output logic                    o_req_ready,
    input  wire logic               i_req_type,
    input  wire logic [INDEX_W-1:0] i_entry_index,
    output logic                    o_rsp_valid,
    input  wire logic               i_rsp_ready,
    output logic      [INDEX_W-1:0] o_granted_index,
    output logic      [2:0]         o_status
);

    t_state             r_state;
    t_state             n_state;
    logic [CFG_W-1:0]   r_cfg;
    logic [INDEX_W-1:0] r_head;
    logic [INDEX_W-1:0] n_head;
    logic               r_nonempty;
    logic               n_nonempty;
    logic [COUNT_W-1:0] r_fresh_issued;
    logic [COUNT_W-1:0] n_fresh_issued;
    logic [COUNT_W-1:0] r_fresh_base;
    logic [COUNT_W-1:0] n_fresh_base;
    logic [POS_W-1:0]   r_fresh_pos;
    logic [POS_W-1:0]   n_fresh_pos;

    logic [CFG_W-1:0]   w_blocks;
    logic [COUNT_W-1:0] w_cap;
    logic               w_accept;
    logic               w_in_pool;
    logic [INDEX_W-1:0] w_fresh_index;
    logic               w_space;
    logic               w_push;
    t_result            w_result;
    t_result            w_rsp;
    logic               w_ram_we;
    logic               w_ram_re;
    logic [LINK_W-1:0]  w_ram_wdata;
    logic [LINK_W-1:0]  w_ram_rdata;

    // usable block count and pool capacity
    always_comb begin
        if (int'(r_cfg) > BLOCK_LIMIT) begin
            w_blocks = CFG_W'(BLOCK_LIMIT);
        end else begin
            w_blocks = r_cfg;
        end
    end

    assign w_cap         = COUNT_W'(int'(w_blocks) * BLOCK_ENTRIES);
    assign w_in_pool     = ({1'b0, i_entry_index} < w_cap);
    assign w_fresh_index = INDEX_W'(r_fresh_base + COUNT_W'(BLOCK_ENTRIES - 1)
                                    - COUNT_W'(r_fresh_pos));
    assign w_ram_wdata   = {r_nonempty, r_head};

    assign o_req_ready = (r_state == S_IDLE) && w_space;
    assign w_accept    = i_req_valid && o_req_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && i_req_type == REQ_ALLOC && r_nonempty) begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_head         = r_head;
        n_nonempty     = r_nonempty;
        n_fresh_issued = r_fresh_issued;
        n_fresh_base   = r_fresh_base;
        n_fresh_pos    = r_fresh_pos;
        w_push         = 1'b0;
        w_result       = '{granted_index: '0, status: ST_EXHAUSTED};
        w_ram_we       = 1'b0;
        w_ram_re       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == REQ_FREE) begin
                        w_push = 1'b1;
                        if (w_in_pool) begin
                            w_ram_we        = 1'b1;
                            n_head          = i_entry_index;
                            n_nonempty      = 1'b1;
                            w_result.status = ST_FREED;
                        end else begin
                            w_result.status = ST_REJECTED;
                        end
                    end else if (r_nonempty) begin
                        // link of the head arrives next cycle
                        w_ram_re = 1'b1;
                    end else if (r_fresh_issued < w_cap) begin
                        w_push                 = 1'b1;
                        w_result.granted_index = w_fresh_index;
                        w_result.status        = ST_FRESH;
                        n_fresh_issued         = r_fresh_issued + COUNT_W'(1);
                        if (int'(r_fresh_pos) == BLOCK_ENTRIES - 1) begin
                            n_fresh_pos  = '0;
                            n_fresh_base = r_fresh_base + COUNT_W'(BLOCK_ENTRIES);
                        end else begin
                            n_fresh_pos = r_fresh_pos + POS_W'(1);
                        end
                    end else begin
                        w_push = 1'b1;
                    end
                end
            end
            S_POP: begin
                w_push                 = 1'b1;
                w_result.granted_index = r_head;
                w_result.status        = ST_REUSED;
                n_head                 = w_ram_rdata[INDEX_W-1:0];
                n_nonempty             = w_ram_rdata[INDEX_W];
            end
            default: begin
                w_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_cfg          <= CFG_RESET;
            r_head         <= '0;
            r_nonempty     <= 1'b0;
            r_fresh_issued <= '0;
            r_fresh_base   <= '0;
            r_fresh_pos    <= '0;
        end else begin
            r_state        <= n_state;
            r_head         <= n_head;
            r_nonempty     <= n_nonempty;
            r_fresh_issued <= n_fresh_issued;
            r_fresh_base   <= n_fresh_base;
            r_fresh_pos    <= n_fresh_pos;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    flpa_link_ram #(
        .DEPTH  (INDEX_SPACE),
        .WIDTH  (LINK_W),
        .ADDR_W (INDEX_W)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (i_entry_index),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (r_head),
        .o_rdata (w_ram_rdata)
    );

    flpa_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_result),
        .o_space (w_space),
        .o_valid (o_rsp_valid),
        .i_ready (i_rsp_ready),
        .o_data  (w_rsp)
    );

    assign o_granted_index = w_rsp.granted_index;
    assign o_status        = w_rsp.status;

    `FLPA_ASSERT_IMP(a_ram_one_port, i_clk, i_rst_n, w_ram_re, !w_ram_we,
                     "link read and write in one cycle")
    `FLPA_ASSERT_NXT(a_pop_follows_read, i_clk, i_rst_n, w_ram_re,
                     (r_state == S_POP && r_head == $past(r_head)),
                     "pop did not follow link read")
    `FLPA_ASSERT_NXT(a_free_pushes_head, i_clk, i_rst_n, w_ram_we,
                     (r_nonempty && r_head == $past(i_entry_index)),
                     "freed entry not at list head")
    `FLPA_ASSERT_IMP(a_fresh_in_block, i_clk, i_rst_n, 1'b1,
                     (r_fresh_issued == r_fresh_base + COUNT_W'(r_fresh_pos)),
                     "fresh counters disagree")

endmodule

`default_nettype wire

// ===== rtl/flpa_link_ram.sv =====
// ----------------------------------------------------------------------------
// flpa_link_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module flpa_link_ram #(
    parameter int DEPTH  = 4096,
    parameter int WIDTH  = 13,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/flpa_out_fifo.sv =====
// ----------------------------------------------------------------------------
// flpa_out_fifo
// two entry result queue between the allocator core and the result channel
// ----------------------------------------------------------------------------
`default_nettype none

`include "free_list_pool_allocator_defines.svh"

module flpa_out_fifo
    import flpa_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_data,
    output logic         o_space,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_data
);

    t_result    r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       w_pop;

    assign w_pop   = o_valid && i_ready;
    assign o_valid = (r_count != 2'd0);
    assign o_space = (r_count != 2'd2);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    `FLPA_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, (o_space || w_pop), "result queue overflow")
    `FLPA_ASSERT_NXT(a_count_tracks, i_clk, i_rst_n, (i_push && !w_pop), (r_count == $past(r_count) + 2'd1), "result count did not grow on push")
    `FLPA_ASSERT_IMP(a_ptr_match, i_clk, i_rst_n, (r_count == 2'd0 || r_count == 2'd2), (r_wr_ptr == r_rd_ptr), "queue pointers out of step")

endmodule

`default_nettype wire
